// ===== src/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants for the dirty rectangle tracker
// Box type, operation and register codes, sequencer states and box helpers.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int CoordBits = 13;
  localparam int AreaBits  = 2 * CoordBits;

  // Present policy: merge when more than CombineCount entries, when the
  // bounding area times AreaWeight reaches the screen area, or when the
  // summed area times SumWeight reaches it.
  localparam int CombineCount = 4;
  localparam int AreaWeight   = 5;
  localparam int SumWeight    = 6;

  localparam logic [CoordBits-1:0] ScreenWidthRst  = 13'd512;
  localparam logic [CoordBits-1:0] ScreenHeightRst = 13'd384;

  typedef logic [CoordBits-1:0] coord_t;

  // Right and bottom are exclusive.
  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef enum logic [1:0] {
    OP_MARK    = 2'd0,
    OP_FULL    = 2'd1,
    OP_PRESENT = 2'd2
  } op_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSCAN,
    S_PSCAN,
    S_PAREA,
    S_PSCR,
    S_PDEC,
    S_EMIT
  } state_t;

  function automatic logic box_empty(input box_t a);
    return (a.r <= a.l) || (a.b <= a.t);
  endfunction

  // Bounding box of two boxes; an empty box contributes nothing.
  function automatic box_t box_bound(input box_t a, input box_t c);
    box_t o;
    if (box_empty(a)) begin
      o = c;
    end else if (box_empty(c)) begin
      o = a;
    end else begin
      o.l = (a.l < c.l) ? a.l : c.l;
      o.t = (a.t < c.t) ? a.t : c.t;
      o.r = (a.r > c.r) ? a.r : c.r;
      o.b = (a.b > c.b) ? a.b : c.b;
    end
    return o;
  endfunction

endpackage

// ===== src/dirty_rect_tracker.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_tracker: dirty rectangle table for a display controller
// Clips, merges and stores dirty rectangles; a present emits the regions.
// ----------------------------------------------------------------------------
// Usage: a mark clips its rectangle to the screen and merges it into the first
// stored rectangle it overlaps or touches, appends it, or folds the full table
// into one bounding box. A whole-screen item replaces the table with the full
// screen. A present emits either one bounding region (combined_mode = 1) or
// every non-empty stored rectangle, flags the final one with last, and clears
// the table. Items are taken one at a time; in_stall stays high while one is
// at work. A kept mark walks the stored entries until one overlaps it or the
// walk ends; a present walks the table to sum the areas and bound the
// entries, then emits its regions, held back while out_stall holds the
// output. A single indexed table read and one shared 13x13 multiplier,
// used for every area and for the screen area, serve the whole sequence.
// The output register lets the next item enter while the final region
// still waits for transfer.
// ----------------------------------------------------------------------------
module dirty_rect_tracker import drt_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic signed [15:0]   rect_left,
  input  logic signed [15:0]   rect_top,
  input  logic signed [15:0]   rect_width,
  input  logic signed [15:0]   rect_height,
  // region channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CoordBits-1:0] out_x,
  output logic [CoordBits-1:0] out_y,
  output logic [CoordBits-1:0] out_width,
  output logic [CoordBits-1:0] out_height,
  output logic                 combined_mode,
  output logic                 last,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TotW  = AreaBits + CntW;
  localparam int A5W   = AreaBits + 3;
  localparam int T6W   = TotW + 3;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state, state_next;
  logic [CntW-1:0]     count, count_next;
  logic [CntW-1:0]     idx, idx_next;
  box_t                nb, nb_next;          // clipped rectangle of a mark
  box_t                comb, comb_next;      // running bounding box
  logic [AreaBits-1:0] prod, prod_next;      // shared multiplier result
  logic                prod_add, prod_add_next;
  logic [TotW-1:0]     total, total_next;    // summed area of entries
  logic [A5W-1:0]      area5, area5_next;
  logic                combined, combined_next;
  logic [IdxW-1:0]     last_nz, last_nz_next; // last non-empty entry
  coord_t              screen_width, screen_height;

  box_t                table_q [TABLE_DEPTH];
  logic                tbl_we;
  logic [IdxW-1:0]     tbl_waddr;
  box_t                tbl_wdata;
  box_t                tbl_rd;

  logic                out_valid_next;
  box_t                out_box, out_box_next;
  logic                combined_mode_next, last_next;

  // --------------------------------------------------------------------------
  // Configuration port: decode on the word select bit only
  // --------------------------------------------------------------------------
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ScreenWidthRst;
      screen_height <= ScreenHeightRst;
    end else if (cfg_we) begin
      unique case (reg_t'(paddr[2]))
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[CoordBits-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(paddr[2]))
      REG_SCREEN_WIDTH:  prdata = {{(32 - CoordBits){1'b0}}, screen_width};
      REG_SCREEN_HEIGHT: prdata = {{(32 - CoordBits){1'b0}}, screen_height};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Clip an incoming mark against the screen (evaluated at accept)
  // --------------------------------------------------------------------------
  logic signed [16:0] right_s, bottom_s, sw_s, sh_s;
  logic signed [16:0] clip_l, clip_t, clip_r, clip_b;
  logic               mark_ok;
  box_t               clip_box;

  always_comb begin
    right_s  = 17'(rect_left) + 17'(rect_width);
    bottom_s = 17'(rect_top) + 17'(rect_height);
    sw_s     = signed'({4'b0, screen_width});
    sh_s     = signed'({4'b0, screen_height});
    clip_l   = rect_left[15] ? '0 : 17'(rect_left);
    clip_t   = rect_top[15]  ? '0 : 17'(rect_top);
    clip_r   = (right_s < sw_s)  ? right_s  : sw_s;
    clip_b   = (bottom_s < sh_s) ? bottom_s : sh_s;
    mark_ok  = (rect_width > 16'sd0) && (rect_height > 16'sd0) &&
               (|screen_width) && (|screen_height) &&
               (clip_l < clip_r) && (clip_t < clip_b);
    clip_box.l = clip_l[CoordBits-1:0];
    clip_box.t = clip_t[CoordBits-1:0];
    clip_box.r = clip_r[CoordBits-1:0];
    clip_box.b = clip_b[CoordBits-1:0];
  end

  // --------------------------------------------------------------------------
  // Shared datapath: one indexed table read, one multiplier
  // --------------------------------------------------------------------------
  coord_t              mul_a, mul_b;
  logic [AreaBits-1:0] mul_p;
  logic                rd_empty, overlap, in_xfer, out_free;
  logic [T6W-1:0]      total6;

  assign tbl_rd   = table_q[idx[IdxW-1:0]];
  assign rd_empty = box_empty(tbl_rd);
  assign overlap  = (nb.l <= tbl_rd.r) && (nb.r >= tbl_rd.l) &&
                    (nb.t <= tbl_rd.b) && (nb.b >= tbl_rd.t);
  assign mul_p    = AreaBits'(mul_a) * AreaBits'(mul_b);
  assign total6   = T6W'(total) * T6W'(SumWeight);
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (state)
      S_PSCAN: begin
        mul_a = tbl_rd.r - tbl_rd.l;
        mul_b = tbl_rd.b - tbl_rd.t;
      end
      S_PAREA: begin
        mul_a = comb.r - comb.l;
        mul_b = comb.b - comb.t;
      end
      default: begin
        mul_a = screen_width;
        mul_b = screen_height;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_next         = state;
    count_next         = count;
    idx_next           = idx;
    nb_next            = nb;
    comb_next          = comb;
    prod_next          = prod;
    prod_add_next      = prod_add;
    total_next         = total;
    area5_next         = area5;
    combined_next      = combined;
    last_nz_next       = last_nz;
    tbl_we             = 1'b0;
    tbl_waddr          = idx[IdxW-1:0];
    tbl_wdata          = nb;
    out_valid_next     = out_valid && out_stall;
    out_box_next       = out_box;
    combined_mode_next = combined_mode;
    last_next          = last;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (op)
            OP_MARK: begin
              // drop empty or off-screen marks at once
              if (mark_ok) begin
                nb_next    = clip_box;
                comb_next  = clip_box;
                idx_next   = '0;
                state_next = S_MSCAN;
              end
            end
            OP_FULL: begin
              tbl_we      = 1'b1;
              tbl_waddr   = '0;
              tbl_wdata.l = '0;
              tbl_wdata.t = '0;
              tbl_wdata.r = screen_width;
              tbl_wdata.b = screen_height;
              count_next  = CntW'(1);
            end
            OP_PRESENT: begin
              if (count != '0) begin
                idx_next      = '0;
                comb_next     = table_q[0];
                total_next    = '0;
                prod_add_next = 1'b0;
                state_next    = S_PSCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_MSCAN: begin
        if (idx == count) begin
          // no stored entry touched: append, or fold the full table
          tbl_we = 1'b1;
          if (count != CntW'(TABLE_DEPTH)) begin
            tbl_waddr  = count[IdxW-1:0];
            tbl_wdata  = nb;
            count_next = count + CntW'(1);
          end else begin
            tbl_waddr  = '0;
            tbl_wdata  = comb;
            count_next = CntW'(1);
          end
          state_next = S_IDLE;
        end else if (overlap) begin
          tbl_we     = 1'b1;
          tbl_wdata  = box_bound(tbl_rd, nb);
          state_next = S_IDLE;
        end else begin
          comb_next = box_bound(comb, tbl_rd);
          idx_next  = idx + CntW'(1);
        end
      end

      S_PSCAN: begin
        comb_next     = box_bound(comb, tbl_rd);
        prod_next     = rd_empty ? '0 : mul_p;
        prod_add_next = 1'b1;
        if (prod_add) begin
          total_next = total + TotW'(prod);
        end
        if (!rd_empty) begin
          last_nz_next = idx[IdxW-1:0];
        end
        idx_next = idx + CntW'(1);
        if (idx + CntW'(1) == count) begin
          state_next = S_PAREA;
        end
      end

      S_PAREA: begin
        // fold in the final entry area, then take the bounding area
        total_next    = total + TotW'(prod);
        prod_add_next = 1'b0;
        prod_next     = mul_p;
        if (box_empty(comb)) begin
          count_next = '0;
          state_next = S_IDLE;
        end else begin
          state_next = S_PSCR;
        end
      end

      S_PSCR: begin
        area5_next = A5W'(prod) * A5W'(AreaWeight);
        prod_next  = mul_p;
        state_next = S_PDEC;
      end

      S_PDEC: begin
        combined_next = (32'(count) > CombineCount) ||
                        (area5 >= A5W'(prod)) ||
                        (total6 >= T6W'(prod));
        idx_next      = '0;
        state_next    = S_EMIT;
      end

      S_EMIT: begin
        if (combined) begin
          if (out_free) begin
            out_valid_next     = 1'b1;
            out_box_next       = comb;
            combined_mode_next = 1'b1;
            last_next          = 1'b1;
            count_next         = '0;
            state_next         = S_IDLE;
          end
        end else if (rd_empty) begin
          // skip empty entries
          idx_next = idx + CntW'(1);
        end else if (out_free) begin
          out_valid_next     = 1'b1;
          out_box_next       = tbl_rd;
          combined_mode_next = 1'b0;
          last_next          = (idx[IdxW-1:0] == last_nz);
          idx_next           = idx + CntW'(1);
          if (idx[IdxW-1:0] == last_nz) begin
            count_next = '0;
            state_next = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      prod_add  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      prod_add  <= prod_add_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    idx           <= idx_next;
    nb            <= nb_next;
    comb          <= comb_next;
    prod          <= prod_next;
    total         <= total_next;
    area5         <= area5_next;
    combined      <= combined_next;
    last_nz       <= last_nz_next;
    out_box       <= out_box_next;
    combined_mode <= combined_mode_next;
    last          <= last_next;
    if (tbl_we) begin
      table_q[tbl_waddr] <= tbl_wdata;
    end
  end

  assign out_x      = out_box.l;
  assign out_y      = out_box.t;
  assign out_width  = out_box.r - out_box.l;
  assign out_height = out_box.b - out_box.t;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TABLE_DEPTH))
    else $error("rect count beyond table depth");

  a_combined_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && combined_mode |-> last)
    else $error("combined region not flagged last");

  a_present_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_PRESENT |=> in_stall || count == '0)
    else $error("present left table entries behind");
`endif

endmodule
